// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define MADF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// When pre holds at one edge, post must hold at the next one.
`define MADF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/madf_pkg.sv
// ----------------------------------------------------------------------------
// ADC deadband filter package
// Sizes, register indexes, reset values and the per-channel state record.
// ----------------------------------------------------------------------------
package madf_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam int CH_W       = 4;
	localparam int RAW_W      = 10;
	localparam int TIME_W     = 16;
	localparam int VAL_W      = 8;
	localparam int WIDTH_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 2'd1;

	localparam logic [WIDTH_W-1:0] WINDOW_WIDTH_RST = 7'd6;
	localparam logic [TIME_W-1:0]  SETTLE_TICKS_RST = 16'd200;

	localparam logic [RAW_W:0] ADC_OFFSET  = 11'd16;
	localparam logic [RAW_W:0] SAMPLE_LOW  = 11'd512;
	localparam logic [RAW_W:0] SAMPLE_HIGH = 11'd1024;
	localparam logic [VAL_W-1:0] VAL_MAX   = 8'hFF;

	localparam logic [CH_W-1:0] LAST_CHANNEL = CH_W'(NUM_CHANNELS - 1);

	typedef struct packed {
		logic [VAL_W-1:0]  win_lo;
		logic [VAL_W-1:0]  win_hi;
		logic [VAL_W-1:0]  recent;
		logic [TIME_W-1:0] stamp;
		logic [VAL_W-1:0]  held;
	} entry_t;

	// Bias the converter result and squeeze it into eight bits.
	function automatic logic [VAL_W-1:0] map_sample(input logic [RAW_W-1:0] raw);
		logic [RAW_W:0] biased;
		biased = {1'b0, raw} + ADC_OFFSET;
		if (biased >= SAMPLE_HIGH) begin
			return VAL_MAX;
		end else if (biased <= SAMPLE_LOW) begin
			return '0;
		end else begin
			return biased[VAL_W:1];
		end
	endfunction

endpackage

// File: rtl/core/madf_if.sv
// ----------------------------------------------------------------------------
// ADC deadband filter channels
// Valid/ready interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
interface madf_sample_if;
	logic                         valid;
	logic                         ready;
	logic [madf_pkg::RAW_W-1:0]   raw_sample;
	logic [madf_pkg::TIME_W-1:0]  time_now;

	modport source (output valid, raw_sample, time_now, input ready);
	modport sink (input valid, raw_sample, time_now, output ready);
endinterface

interface madf_result_if;
	logic                        valid;
	logic                        ready;
	logic [madf_pkg::CH_W-1:0]   channel;
	logic [madf_pkg::VAL_W-1:0]  held_value;
	logic                        changed;
	logic                        scan_wrap;

	modport source (output valid, channel, held_value, changed, scan_wrap, input ready);
	modport sink (input valid, channel, held_value, changed, scan_wrap, output ready);
endinterface

interface madf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [madf_pkg::CFG_IDX_W-1:0]   index;
	logic [madf_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/madf_update.sv
// ----------------------------------------------------------------------------
// ADC deadband filter channel update
// Maps one sample and computes the next window, stamp and held value.
// ----------------------------------------------------------------------------
module madf_update (
	input  logic [madf_pkg::RAW_W-1:0]   raw_sample,
	input  logic [madf_pkg::TIME_W-1:0]  time_now,
	input  logic [madf_pkg::WIDTH_W-1:0] window_width,
	input  logic [madf_pkg::TIME_W-1:0]  settle_ticks,
	input  madf_pkg::entry_t             cur,
	output madf_pkg::entry_t             nxt,
	output logic                         changed
);

	logic [madf_pkg::VAL_W-1:0]  sample;
	logic [madf_pkg::VAL_W-1:0]  w8;
	logic [madf_pkg::VAL_W-1:0]  half;
	logic [madf_pkg::TIME_W-1:0] elapsed;

	assign sample  = madf_pkg::map_sample(raw_sample);
	assign w8      = {1'b0, window_width};
	assign half    = {2'b00, window_width[madf_pkg::WIDTH_W-1:1]};
	// Modulo subtraction keeps the quiet time right across a tick wrap.
	assign elapsed = time_now - cur.stamp;

	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		if (sample < cur.win_lo) begin
			nxt.win_lo = sample;
			changed    = 1'b1;
			if (8'(cur.win_hi - sample) > w8) begin
				nxt.win_hi = 8'(sample + w8);
			end
		end else if (sample > cur.win_hi) begin
			nxt.win_hi = sample;
			changed    = 1'b1;
			if (8'(sample - cur.win_lo) > w8) begin
				nxt.win_lo = 8'(sample - w8);
			end
		end else if (elapsed >= settle_ticks) begin
			// Re-center on the last value, leaving a bound alone where it would wrap.
			nxt.stamp = time_now;
			if (cur.recent >= half) begin
				nxt.win_lo = 8'(cur.recent - half);
			end
			if (cur.recent <= 8'(madf_pkg::VAL_MAX - half)) begin
				nxt.win_hi = 8'(cur.recent + half);
			end
		end
		if (changed) begin
			nxt.stamp  = time_now;
			nxt.recent = sample;
			nxt.held   = sample;
		end
	end

endmodule

// File: rtl/core/multichannel_adc_deadband_filter_top.sv
// ----------------------------------------------------------------------------
// Multichannel ADC deadband filter
// Round-robin hysteresis filter over a per-channel state memory.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the sample channel, one per transfer, for channels
// 0 .. NUM_CHANNELS-1 in turn; the block tracks the scan position itself.
// Each sample yields exactly one transfer on the result channel, carrying the
// channel, its held value, a changed flag and a flag set when the next sample
// belongs to channel zero. Registers are written on the cfg channel, which is
// always ready; write them only while no sample is in flight.
// The result is valid once the update stage advances: the transfer edge reads
// the channel's entry from the state memory, and the advancing edge writes
// the computed update back and loads the output register. One sample per
// cycle is sustained while results are taken. Back-to-back samples of the
// same entry are served by forwarding the write-back data into the next read.
// When the result receiver stalls, the output register holds, the update stage
// fills behind it and sample ready drops; nothing is lost.
// Reset clears the scan position and all entry valid bits, so every channel
// reads as all-zero state until first written; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multichannel_adc_deadband_filter_top (
	input  logic         clk,
	input  logic         arst_n,
	madf_sample_if.sink  sample,
	madf_result_if.source result,
	madf_cfg_if.sink     cfg
);

	localparam int N  = madf_pkg::NUM_CHANNELS;
	localparam int AW = madf_pkg::ADDR_W;

	// Configuration registers.
	logic [madf_pkg::WIDTH_W-1:0] window_width_q;
	logic [madf_pkg::TIME_W-1:0]  settle_ticks_q;

	// Scan position and state memory.
	logic [madf_pkg::CH_W-1:0] chan_q;
	logic [madf_pkg::CH_W-1:0] chan_cur;
	logic [madf_pkg::CH_W-1:0] chan_next;
	logic [AW-1:0]             rd_addr;
	madf_pkg::entry_t          mem [N];
	logic [N-1:0]              vld_q;

	// Update stage.
	logic                         s1_valid;
	logic [madf_pkg::RAW_W-1:0]   raw_s1;
	logic [madf_pkg::TIME_W-1:0]  now_s1;
	logic [madf_pkg::CH_W-1:0]    chan_s1;
	logic                         wrap_s1;
	madf_pkg::entry_t             rd_s1;
	logic                         rdv_s1;
	logic                         fwd_s1;
	madf_pkg::entry_t             fwd_data_s1;
	madf_pkg::entry_t             cur;
	madf_pkg::entry_t             nxt;
	logic                         changed;
	logic                         s1_adv;
	logic                         accept;
	logic [AW-1:0]                wr_addr;

	// Output register.
	logic                        out_valid_q;
	logic [madf_pkg::CH_W-1:0]   out_chan_q;
	logic [madf_pkg::VAL_W-1:0]  out_held_q;
	logic                        out_changed_q;
	logic                        out_wrap_q;

	assign chan_cur  = (chan_q > madf_pkg::LAST_CHANNEL) ? '0 : chan_q;
	assign chan_next = (chan_cur == madf_pkg::LAST_CHANNEL) ? '0 : chan_cur + 1'b1;
	assign rd_addr   = chan_cur[AW-1:0];
	assign wr_addr   = chan_s1[AW-1:0];

	assign s1_adv       = s1_valid && (!out_valid_q || result.ready);
	assign sample.ready = !s1_valid || s1_adv;
	assign accept       = sample.valid && sample.ready;

	// A never-written entry reads as zero; a same-entry write in the read
	// cycle takes precedence over the memory contents.
	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (rdv_s1) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end
	end

	madf_update u_update (
		.raw_sample   (raw_s1),
		.time_now     (now_s1),
		.window_width (window_width_q),
		.settle_ticks (settle_ticks_q),
		.cur          (cur),
		.nxt          (nxt),
		.changed      (changed)
	);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			mem[wr_addr] <= nxt;
		end
		if (accept) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1      <= sample.raw_sample;
			now_s1      <= sample.time_now;
			chan_s1     <= chan_cur;
			wrap_s1     <= (chan_next == '0);
			fwd_data_s1 <= nxt;
		end
		if (s1_adv) begin
			out_chan_q    <= chan_s1;
			out_held_q    <= nxt.held;
			out_changed_q <= changed;
			out_wrap_q    <= wrap_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= '0;
			vld_q       <= '0;
			s1_valid    <= 1'b0;
			rdv_s1      <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (accept) begin
				chan_q   <= chan_next;
				s1_valid <= 1'b1;
				rdv_s1   <= vld_q[rd_addr];
				fwd_s1   <= s1_adv && (wr_addr == rd_addr);
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q <= madf_pkg::WINDOW_WIDTH_RST;
			settle_ticks_q <= madf_pkg::SETTLE_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				madf_pkg::REG_WINDOW_WIDTH: window_width_q <= cfg.data[madf_pkg::WIDTH_W-1:0];
				madf_pkg::REG_SETTLE_TICKS: settle_ticks_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.channel    = out_chan_q;
	assign result.held_value = out_held_q;
	assign result.changed    = out_changed_q;
	assign result.scan_wrap  = out_wrap_q;

	`MADF_ASSERT(a_chan_range, chan_q <= madf_pkg::LAST_CHANNEL, "scan position out of range")
	`MADF_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid, "accepted sample missing from update stage")
	`MADF_ASSERT(a_wrap_matches, out_valid_q |-> (out_wrap_q == (out_chan_q == madf_pkg::LAST_CHANNEL)), "scan wrap flag disagrees with channel")
	`MADF_ASSERT(a_changed_stores, (s1_valid && changed) |-> (nxt.held == nxt.recent && nxt.stamp == now_s1), "changed sample not stored")

endmodule
